// ----- src/usbhid_pkg.sv -----
// Shared types and constants of the HID boot interrupt endpoint finder.
// No dependencies; used by every module of the block.
package usbhid_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MpsW  = 11;
  localparam int unsigned ProtW = 2;

  // Descriptor type codes and minimum lengths.
  localparam logic [ByteW-1:0] DescTypeInterface = 8'd4;
  localparam logic [ByteW-1:0] DescTypeEndpoint  = 8'd5;
  localparam logic [ByteW-1:0] IfaceMinLen       = 8'd9;
  localparam logic [ByteW-1:0] EpMinLen          = 8'd7;
  localparam logic [ByteW-1:0] MinDescLen        = 8'd2;

  // Interface class codes and boot protocols.
  localparam logic [ByteW-1:0] HidClass      = 8'd3;
  localparam logic [ByteW-1:0] BootSubclass  = 8'd1;
  localparam logic [ByteW-1:0] ProtoKeyboard = 8'd1;
  localparam logic [ByteW-1:0] ProtoMouse    = 8'd2;

  // Endpoint attribute and address fields.
  localparam logic [1:0]      XferTypeInterrupt = 2'd3;
  localparam int unsigned     EpDirInBit        = 7;
  localparam logic [MpsW-1:0] MpsDefault        = 11'd8;

  // Byte offsets inside a descriptor.
  localparam logic [ByteW-1:0] PosType      = 8'd1;
  localparam logic [ByteW-1:0] PosIfNumber  = 8'd2;
  localparam logic [ByteW-1:0] PosIfClass   = 8'd5;
  localparam logic [ByteW-1:0] PosIfSubcl   = 8'd6;
  localparam logic [ByteW-1:0] PosIfProto   = 8'd7;
  localparam logic [ByteW-1:0] PosEpAddr    = 8'd2;
  localparam logic [ByteW-1:0] PosEpAttr    = 8'd3;
  localparam logic [ByteW-1:0] PosEpMpsLow  = 8'd4;
  localparam logic [ByteW-1:0] PosEpMpsHigh = 8'd5;
  localparam logic [ByteW-1:0] PosEpIntvl   = 8'd6;

  typedef struct packed {
    logic             found;
    logic [ByteW-1:0] interface_number;
    logic [ProtW-1:0] protocol;
    logic [ByteW-1:0] endpoint_address;
    logic [MpsW-1:0]  max_packet_size;
    logic [ByteW-1:0] poll_interval;
  } result_t;

endpackage

// ----- src/usb_hid_interrupt_endpoint_finder.sv -----
// Finds the first HID boot interrupt IN endpoint in a USB configuration descriptor set.
// Top level; depends on usbhid_pkg, usbhid_walker and usbhid_out_stage.
//
// Input channel (in_valid_i / in_ready_o): one descriptor byte per transfer, with
// last_byte_i marking the final byte of a descriptor set.
// Output channel (out_valid_o / out_ready_i): one result per descriptor set, either
// the matching endpoint (found_o = 1) on the byte that completes the first match,
// or a not-found result with all fields zero on the last byte.
// A byte is taken into an input register; from there the walker logic acts on it
// and, if it causes a result, writes the result register, which drives out_valid_o.
// Throughput is one byte per cycle while the input side is not stalled. A byte that
// causes no result always moves on; a byte that causes a result waits in the input
// register only while the result register is still full and out_ready_i is low, so
// the receiver stalls the input side only then.
// Reset clears the walk state and both valid flags; the next byte begins a new
// descriptor set. After the last byte of a set the walk state returns to reset.
module usb_hid_interrupt_endpoint_finder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [usbhid_pkg::ByteW-1:0]        desc_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic [usbhid_pkg::ByteW-1:0]        interface_number_o,
  output logic [usbhid_pkg::ProtW-1:0]        protocol_o,
  output logic [usbhid_pkg::ByteW-1:0]        endpoint_address_o,
  output logic [usbhid_pkg::MpsW-1:0]         max_packet_size_o,
  output logic [usbhid_pkg::ByteW-1:0]        poll_interval_o
);
  import usbhid_pkg::*;

  logic             stage_valid_q, stage_valid_d;
  logic [ByteW-1:0] stage_byte_q;
  logic             stage_last_q;
  logic             accept;
  logic             step;
  logic             emit;
  logic             slot_free;
  result_t          walk_res;
  result_t          out_res;

  // The held byte moves on unless it causes a result that has nowhere to go.
  assign step       = stage_valid_q && (!emit || slot_free);
  assign in_ready_o = !stage_valid_q || step;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (step) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_byte_q <= desc_byte_i;
      stage_last_q <= last_byte_i;
    end
  end

  usbhid_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (stage_byte_q),
    .last_i (stage_last_q),
    .emit_o (emit),
    .res_o  (walk_res)
  );

  usbhid_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && emit),
    .res_i   (walk_res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .free_o  (slot_free),
    .res_o   (out_res)
  );

  assign found_o            = out_res.found;
  assign interface_number_o = out_res.interface_number;
  assign protocol_o         = out_res.protocol;
  assign endpoint_address_o = out_res.endpoint_address;
  assign max_packet_size_o  = out_res.max_packet_size;
  assign poll_interval_o    = out_res.poll_interval;

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> interface_number_o == '0 && protocol_o == '0 &&
      endpoint_address_o == '0 && max_packet_size_o == '0 && poll_interval_o == '0)
    else $error("not-found result carries nonzero fields");

  a_found_protocol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> protocol_o == 2'd1 || protocol_o == 2'd2)
    else $error("match reported without a boot protocol");

  a_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> max_packet_size_o != '0 && endpoint_address_o[EpDirInBit])
    else $error("match reported with zero packet size or OUT direction");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !step |=> stage_valid_q && $stable(stage_byte_q) &&
      $stable(stage_last_q))
    else $error("held descriptor byte lost or changed while stalled");
`endif

endmodule

// ----- src/usbhid_walker.sv -----
// Descriptor walker: per-byte state of the descriptor set and the result it causes.
// Depends on usbhid_pkg.
module usbhid_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [usbhid_pkg::ByteW-1:0] byte_i,
  input  logic                        last_i,
  output logic                        emit_o,
  output usbhid_pkg::result_t         res_o
);
  import usbhid_pkg::*;

  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] cur_if_q, cur_if_d;
  logic [ProtW-1:0] cur_prot_q, cur_prot_d;
  logic             class_hid_q, class_hid_d;
  logic             subcl_boot_q, subcl_boot_d;
  logic [ByteW-1:0] pend_if_q, pend_if_d;
  logic [ByteW-1:0] pend_prot_q, pend_prot_d;
  logic [ByteW-1:0] ep_addr_q, ep_addr_d;
  logic             ep_intr_q, ep_intr_d;
  logic [ByteW-1:0] mps_low_q, mps_low_d;
  logic [2:0]       mps_high_q, mps_high_d;
  logic [ByteW-1:0] intvl_q, intvl_d;
  logic             stopped_q, stopped_d;
  logic             given_q, given_d;

  logic             match;
  logic [MpsW-1:0]  mps_raw;

  always_comb begin
    pos_d        = pos_q;
    len_d        = len_q;
    type_d       = type_q;
    cur_if_d     = cur_if_q;
    cur_prot_d   = cur_prot_q;
    class_hid_d  = class_hid_q;
    subcl_boot_d = subcl_boot_q;
    pend_if_d    = pend_if_q;
    pend_prot_d  = pend_prot_q;
    ep_addr_d    = ep_addr_q;
    ep_intr_d    = ep_intr_q;
    mps_low_d    = mps_low_q;
    mps_high_d   = mps_high_q;
    intvl_d      = intvl_q;
    stopped_d    = stopped_q;
    given_d      = given_q;
    match        = 1'b0;

    if (!given_q && !stopped_q) begin
      if (pos_q == '0) begin
        if (byte_i < MinDescLen) begin
          stopped_d = 1'b1;
        end else begin
          len_d = byte_i;
          pos_d = 8'd1;
        end
      end else begin
        if (pos_q == PosType) begin
          type_d = byte_i;
        end else if (type_q == DescTypeInterface) begin
          case (pos_q)
            PosIfNumber: pend_if_d    = byte_i;
            PosIfClass:  class_hid_d  = (byte_i == HidClass);
            PosIfSubcl:  subcl_boot_d = (byte_i == BootSubclass);
            PosIfProto:  pend_prot_d  = byte_i;
            default: ;
          endcase
        end else if (type_q == DescTypeEndpoint) begin
          case (pos_q)
            PosEpAddr:    ep_addr_d  = byte_i;
            PosEpAttr:    ep_intr_d  = (byte_i[1:0] == XferTypeInterrupt);
            PosEpMpsLow:  mps_low_d  = byte_i;
            PosEpMpsHigh: mps_high_d = byte_i[2:0];
            PosEpIntvl:   intvl_d    = byte_i;
            default: ;
          endcase
        end

        // The last byte of a descriptor acts on the values captured so far,
        // including the one captured from this very byte.
        if ({1'b0, pos_q} + 9'd1 == {1'b0, len_q}) begin
          pos_d = '0;
          if (type_d == DescTypeInterface && len_q >= IfaceMinLen) begin
            cur_if_d   = pend_if_d;
            cur_prot_d = '0;
            if (class_hid_d && subcl_boot_d &&
                (pend_prot_d == ProtoKeyboard || pend_prot_d == ProtoMouse)) begin
              cur_prot_d = pend_prot_d[ProtW-1:0];
            end
          end else if (type_d == DescTypeEndpoint && len_q >= EpMinLen) begin
            match = (cur_prot_q != '0) && ep_intr_d && ep_addr_d[EpDirInBit];
          end
          if (match) begin
            given_d = 1'b1;
          end
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
    end

    // The result is built before the end of the set clears the captured fields.
    mps_raw = {mps_high_d, mps_low_d};
    res_o   = '0;
    if (match) begin
      res_o.found            = 1'b1;
      res_o.interface_number = cur_if_q;
      res_o.protocol         = cur_prot_q;
      res_o.endpoint_address = ep_addr_d;
      res_o.max_packet_size  = (mps_raw == '0) ? MpsDefault : mps_raw;
      res_o.poll_interval    = intvl_d;
    end

    // End of the set: everything returns to its reset value.
    if (last_i) begin
      pos_d        = '0;
      len_d        = '0;
      type_d       = '0;
      cur_if_d     = '0;
      cur_prot_d   = '0;
      class_hid_d  = 1'b0;
      subcl_boot_d = 1'b0;
      pend_if_d    = '0;
      pend_prot_d  = '0;
      ep_addr_d    = '0;
      ep_intr_d    = 1'b0;
      mps_low_d    = '0;
      mps_high_d   = '0;
      intvl_d      = '0;
      stopped_d    = 1'b0;
      given_d      = 1'b0;
    end
  end

  assign emit_o  = match || (last_i && !given_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      len_q        <= '0;
      type_q       <= '0;
      cur_if_q     <= '0;
      cur_prot_q   <= '0;
      class_hid_q  <= 1'b0;
      subcl_boot_q <= 1'b0;
      pend_if_q    <= '0;
      pend_prot_q  <= '0;
      ep_addr_q    <= '0;
      ep_intr_q    <= 1'b0;
      mps_low_q    <= '0;
      mps_high_q   <= '0;
      intvl_q      <= '0;
      stopped_q    <= 1'b0;
      given_q      <= 1'b0;
    end else if (step_i) begin
      pos_q        <= pos_d;
      len_q        <= len_d;
      type_q       <= type_d;
      cur_if_q     <= cur_if_d;
      cur_prot_q   <= cur_prot_d;
      class_hid_q  <= class_hid_d;
      subcl_boot_q <= subcl_boot_d;
      pend_if_q    <= pend_if_d;
      pend_prot_q  <= pend_prot_d;
      ep_addr_q    <= ep_addr_d;
      ep_intr_q    <= ep_intr_d;
      mps_low_q    <= mps_low_d;
      mps_high_q   <= mps_high_d;
      intvl_q      <= intvl_d;
      stopped_q    <= stopped_d;
      given_q      <= given_d;
    end
  end

endmodule

// ----- src/usbhid_out_stage.sv -----
// Result register of the finder: holds one result until the receiver takes it.
// Depends on usbhid_pkg.
module usbhid_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  usbhid_pkg::result_t res_i,
  input  logic                ready_i,
  output logic                valid_o,
  output logic                free_o,
  output usbhid_pkg::result_t res_o
);
  import usbhid_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
